/* rtl/core/wall_force_secant_servo_defines.svh */
// Assertion macros for the wall force servo checkers.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef WALL_FORCE_SECANT_SERVO_DEFINES_SVH
`define WALL_FORCE_SECANT_SERVO_DEFINES_SVH

// Clocked check, off while reset is held
`define WFS_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// A stalled beat keeps its valid and its payload
`define WFS_CHECK_HOLD(name, vld, rdy, sig) \
  `WFS_CHECK(name, (vld && !rdy) |=> (vld && $stable(sig)))

`endif

/* rtl/core/wfs_pkg.sv */
// Shared types, constants and fixed-point helpers for the wall force servo.
// No dependencies; every module of the block imports this package.
package wfs_pkg;

  // Number format: signed Q24.24 in VW bits
  localparam int VW  = 48;
  localparam int FW  = 24;
  localparam int HW  = VW / 2;
  localparam int RW  = VW - 1;
  localparam int TFW = 32;
  localparam int AW  = 2 * VW;
  localparam int BRW = 3;
  localparam int IDXW = 3;
  localparam int IN_TDATA_W  = ((2 * VW + RW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VW + 7) / 8) * 8;

  typedef logic signed [VW-1:0] val_t;
  typedef logic [VW-1:0]        mag_t;
  typedef logic [BRW-1:0]       branch_t;
  typedef logic [IDXW-1:0]      reg_idx_t;
  typedef logic [2:0]           op_t;

  localparam val_t VMAX     = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VMIN     = {1'b1, {(VW-1){1'b0}}};
  localparam mag_t VMAX_MAG = {1'b0, {(VW-1){1'b1}}};
  localparam val_t BOOST_Q  = val_t'(18454938);
  localparam logic [RW-1:0] ONE_Q = {{(RW-FW-1){1'b0}}, 1'b1, {FW{1'b0}}};

  // Branch codes reported with each result
  localparam branch_t BR_NONE   = 3'd0;
  localparam branch_t BR_BOOST  = 3'd1;
  localparam branch_t BR_SECANT = 3'd2;
  localparam branch_t BR_STIFF  = 3'd3;
  localparam branch_t BR_FULL   = 3'd4;

  // Configuration register indexes
  localparam reg_idx_t REG_TARGET_STRESS = 3'd0;
  localparam reg_idx_t REG_LOADED_AREA   = 3'd1;
  localparam reg_idx_t REG_THRESHOLD     = 3'd2;
  localparam reg_idx_t REG_MAX_VELOCITY  = 3'd3;
  localparam reg_idx_t REG_TIME_STEP     = 3'd4;

  // Datapath operations: operand selection and result destination
  localparam op_t OP_TF  = 3'd0;  // target force
  localparam op_t OP_THR = 3'd1;  // overshoot threshold
  localparam op_t OP_LIM = 3'd2;  // step limit
  localparam op_t OP_BST = 3'd3;  // boosted step
  localparam op_t OP_NUM = 3'd4;  // secant numerator
  localparam op_t OP_SEC = 3'd5;  // secant quotient
  localparam op_t OP_STF = 3'd6;  // error over stiffness
  localparam op_t OP_VEL = 3'd7;  // velocity

  typedef struct packed {
    logic    load;
    logic    mul_go;
    logic    div_go;
    logic    cap;
    op_t     op;
    logic    set_br;
    branch_t br;
    logic    take_lim;
    logic    set_nc;
    logic    upd;
    logic    push;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic no_contact;
    logic use_secant;
    logic use_boost;
    logic stiff_nz;
    logic out_free;
  } stat_t;

  function automatic mag_t mag_of(val_t a);
    return a[VW-1] ? mag_t'(-a) : mag_t'(a);
  endfunction

  // Signed value from a magnitude, saturating
  function automatic val_t from_mag(logic neg, logic ovf, mag_t m);
    if (ovf || (m > VMAX_MAG)) return neg ? VMIN : VMAX;
    return neg ? val_t'(-m) : val_t'(m);
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic [VW:0] d;
    d = {a[VW-1], a} - {b[VW-1], b};
    if (d[VW] != d[VW-1]) return d[VW] ? VMIN : VMAX;
    return val_t'(d[VW-1:0]);
  endfunction

endpackage

/* rtl/core/wall_force_secant_servo.sv */
// Timing: a division cut short (zero dividend or divisor, overflow) ends early, and a result
// held in the output register delays the return to idle.
// Throughput: one item in flight, the next beat taken the cycle after the result is pushed;
// all operations share the one sequential divider and the one 24x24 multiplier.
// Reset (rst_n, synchronous) restores register defaults and clears previous position/error.
module wall_force_secant_servo import wfs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // wall_force, wall_position, contact_stiffness
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // wall_velocity
  output logic [BRW-1:0]         out_tuser,  // branch_taken
  // configuration writes
  input  logic                   cfg_we,
  input  reg_idx_t               cfg_index,
  input  logic [RW-1:0]          cfg_wdata
);

  cmd_t    cmd;
  stat_t   stat;
  val_t    out_vel;
  branch_t out_br;

  wfs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid_i (in_tvalid),
    .in_tready_o (in_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wfs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .force_i      (val_t'(in_tdata[VW-1:0])),
    .pos_i        (val_t'(in_tdata[2*VW-1:VW])),
    .stiff_i      (in_tdata[2*VW+RW-1:2*VW]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_tready_i (out_tready),
    .out_tvalid_o (out_tvalid),
    .out_vel_o    (out_vel),
    .out_br_o     (out_br)
  );

  assign out_tdata = OUT_TDATA_W'(mag_t'(out_vel));
  assign out_tuser = out_br;

endmodule

/* rtl/core/wfs_mul.sv */
// Sequential Q24.24 multiplier: four half-width partial products, saturating.
// Depends on wfs_pkg.
module wfs_mul import wfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start_i,
  input  val_t a_i,
  input  val_t b_i,
  output logic done_o,
  output val_t res_o
);

  localparam logic [2:0] PP_COUNT  = 3'd4;
  localparam logic [2:0] FIN_COUNT = 3'd5;

  logic          busy_r;
  logic          done_r;
  logic [2:0]    cnt_r;
  logic          pp_vld_r;
  mag_t          a_r;
  mag_t          b_r;
  logic          neg_r;
  logic [VW-1:0] pp_r;
  logic [1:0]    pp_sh_r;
  logic [AW-1:0] acc_r;
  val_t          res_r;

  logic [HW-1:0] a_half;
  logic [HW-1:0] b_half;
  logic [VW-1:0] pp_nxt;
  logic [1:0]    pp_sh_nxt;
  logic [AW-1:0] pp_ext;
  logic [AW-1:0] pp_aligned;
  logic [AW-1:0] acc_nxt;
  val_t          res_nxt;

  // Pick halves for this partial product
  assign a_half    = cnt_r[1] ? a_r[VW-1:HW] : a_r[HW-1:0];
  assign b_half    = cnt_r[0] ? b_r[VW-1:HW] : b_r[HW-1:0];
  assign pp_nxt    = a_half * b_half;
  assign pp_sh_nxt = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};

  // Align the registered partial product and accumulate
  assign pp_ext = AW'(pp_r);
  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_aligned = pp_ext;
      2'd1:    pp_aligned = pp_ext << HW;
      2'd2:    pp_aligned = pp_ext << (2 * HW);
      default: pp_aligned = '0;
    endcase
  end
  assign acc_nxt = acc_r + pp_aligned;
  assign res_nxt = from_mag(neg_r, |acc_r[AW-1:FW+VW], acc_r[FW+VW-1:FW]);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
      pp_vld_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        pp_vld_r <= 1'b0;
      end else if (busy_r) begin
        pp_vld_r <= (cnt_r < PP_COUNT);
        cnt_r    <= cnt_r + 3'd1;
        if (cnt_r == FIN_COUNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      a_r   <= mag_of(a_i);
      b_r   <= mag_of(b_i);
      neg_r <= a_i[VW-1] ^ b_i[VW-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < PP_COUNT) begin
        pp_r    <= pp_nxt;
        pp_sh_r <= pp_sh_nxt;
      end
      if (pp_vld_r) acc_r <= acc_nxt;
      if (cnt_r == FIN_COUNT) res_r <= res_nxt;
    end
  end

  assign done_o = done_r;
  assign res_o  = res_r;

endmodule

/* rtl/core/wfs_div.sv */
// Bit-serial Q24.24 divider: restoring division, one quotient bit a cycle,
// saturating on overflow or a zero divisor. Depends on wfs_pkg.
module wfs_div import wfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start_i,
  input  val_t a_i,
  input  val_t b_i,
  output logic done_o,
  output val_t res_o
);

  localparam int CW = $clog2(VW);
  localparam logic [CW-1:0] LAST_STEP = CW'(VW - 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CHECK = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  logic [1:0]    phase_r;
  logic [1:0]    phase_nxt;
  logic          done_r;
  logic          done_nxt;
  logic [CW-1:0] cnt_r;
  mag_t          x_r;
  mag_t          d_r;
  logic          neg_r;
  mag_t          rem_r;
  mag_t          lo_r;
  mag_t          q_r;
  val_t          res_r;

  logic [VW:0]   sh;
  logic          ge;
  logic [VW:0]   diff;
  mag_t          rem_nxt;
  mag_t          q_nxt;

  // One restoring step
  assign sh      = {rem_r, lo_r[VW-1]};
  assign ge      = (sh >= {1'b0, d_r});
  assign diff    = sh - {1'b0, d_r};
  assign rem_nxt = ge ? diff[VW-1:0] : sh[VW-1:0];
  assign q_nxt   = {q_r[VW-2:0], ge};

  // Phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start_i) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        if ((x_r == '0) || (d_r == '0) || ((x_r >> (VW - FW)) >= d_r)) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end else begin
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN: begin
        if (cnt_r == LAST_STEP) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r   <= mag_of(a_i);
      d_r   <= mag_of(b_i);
      neg_r <= a_i[VW-1] ^ b_i[VW-1];
    end
    case (phase_r)
      PH_CHECK: begin
        // zero dividend, zero divisor and quotient overflow end here
        if (x_r == '0) begin
          res_r <= '0;
        end else if ((d_r == '0) || ((x_r >> (VW - FW)) >= d_r)) begin
          res_r <= from_mag(neg_r, 1'b1, '0);
        end
        rem_r <= x_r >> (VW - FW);
        lo_r  <= x_r << FW;
        q_r   <= '0;
        cnt_r <= '0;
      end
      PH_RUN: begin
        rem_r <= rem_nxt;
        lo_r  <= lo_r << 1;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST_STEP) res_r <= from_mag(neg_r, 1'b0, q_nxt);
      end
      default: ;
    endcase
  end

  assign done_o = done_r;
  assign res_o  = res_r;

endmodule

/* rtl/core/wfs_dp.sv */
// Datapath of the wall force servo: configuration, input and state
// registers, operand selection, shared multiplier and divider, output register.
// Depends on wfs_pkg, wfs_mul and wfs_div.
module wfs_dp import wfs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  reg_idx_t      cfg_index,
  input  logic [RW-1:0] cfg_wdata,
  input  val_t          force_i,
  input  val_t          pos_i,
  input  logic [RW-1:0] stiff_i,
  input  cmd_t          cmd_i,
  output stat_t         stat_o,
  input  logic          out_tready_i,
  output logic          out_tvalid_o,
  output val_t          out_vel_o,
  output branch_t       out_br_o
);

  // Configuration
  logic [RW-1:0]  ts_r;
  logic [RW-1:0]  la_r;
  logic [TFW-1:0] tf_r;
  logic [RW-1:0]  mv_r;
  logic [RW-1:0]  dt_r;

  // Item, state and working values
  val_t          force_r;
  val_t          wpos_r;
  logic [RW-1:0] stiff_r;
  val_t          ppos_r;
  val_t          perr_r;
  val_t          tforce_r;
  val_t          thr_r;
  val_t          lim_r;
  val_t          err_r;
  val_t          num_r;
  val_t          step_r;
  val_t          vel_r;
  branch_t       br_r;

  // Output register
  logic          ovld_r;
  val_t          ovel_r;
  branch_t       obr_r;

  val_t mul_a;
  val_t mul_b;
  val_t div_a;
  val_t div_b;
  val_t mul_res;
  val_t div_res;
  logic mul_done;
  logic div_done;
  mag_t step_cap;
  val_t vel_num;
  val_t nc_vel;
  logic err_pos;
  logic err_neg;
  logic perr_pos;
  logic perr_neg;
  mag_t err_mag;

  assign err_neg  = err_r[VW-1];
  assign err_pos  = !err_r[VW-1] && (err_r != '0);
  assign perr_neg = perr_r[VW-1];
  assign perr_pos = !perr_r[VW-1] && (perr_r != '0);
  assign err_mag  = mag_of(err_r);

  // Cap the step at the limit and sign it by the error
  assign step_cap = (mag_of(step_r) > mag_of(lim_r)) ? mag_of(lim_r) : mag_of(step_r);
  assign vel_num  = (err_r == '0) ? '0 : from_mag(err_neg, 1'b0, step_cap);
  assign nc_vel   = (err_r == '0) ? '0 : from_mag(err_neg, 1'b0, mag_t'(mv_r));

  // Operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_a = '0;
    div_b = '0;
    case (cmd_i.op)
      OP_TF: begin
        mul_a = val_t'(mag_t'(ts_r));
        mul_b = val_t'(mag_t'(la_r));
      end
      OP_THR: begin
        mul_a = val_t'(mag_t'(tf_r));
        mul_b = tforce_r;
      end
      OP_LIM: begin
        mul_a = val_t'(mag_t'(mv_r));
        mul_b = val_t'(mag_t'(dt_r));
      end
      OP_BST: begin
        mul_a = BOOST_Q;
        mul_b = sat_sub(ppos_r, wpos_r);
      end
      OP_NUM: begin
        mul_a = err_r;
        mul_b = sat_sub(wpos_r, ppos_r);
      end
      OP_SEC: begin
        div_a = num_r;
        div_b = sat_sub(err_r, perr_r);
      end
      OP_STF: begin
        div_a = err_r;
        div_b = val_t'(mag_t'(stiff_r));
      end
      OP_VEL: begin
        div_a = vel_num;
        div_b = val_t'(mag_t'(dt_r));
      end
      default: ;
    endcase
  end

  wfs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  wfs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.div_go),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= '0;
      la_r <= ONE_Q;
      tf_r <= '0;
      mv_r <= '0;
      dt_r <= ONE_Q;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_STRESS: ts_r <= cfg_wdata;
        REG_LOADED_AREA:   la_r <= cfg_wdata;
        REG_THRESHOLD:     tf_r <= cfg_wdata[TFW-1:0];
        REG_MAX_VELOCITY:  mv_r <= cfg_wdata;
        REG_TIME_STEP:     dt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Previous position and error, kept across items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppos_r <= '0;
      perr_r <= '0;
    end else if (cmd_i.upd) begin
      ppos_r <= wpos_r;
      perr_r <= err_r;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      force_r <= force_i;
      wpos_r  <= pos_i;
      stiff_r <= stiff_i;
    end
    if (cmd_i.mul_go && (cmd_i.op == OP_THR)) err_r <= sat_sub(force_r, tforce_r);
    if (cmd_i.cap) begin
      case (cmd_i.op)
        OP_TF:   tforce_r <= mul_res;
        OP_THR:  thr_r    <= mul_res;
        OP_LIM:  lim_r    <= mul_res;
        OP_BST:  step_r   <= mul_res;
        OP_NUM:  num_r    <= mul_res;
        OP_SEC:  step_r   <= div_res;
        OP_STF:  step_r   <= div_res;
        OP_VEL:  vel_r    <= div_res;
        default: ;
      endcase
    end
    if (cmd_i.take_lim) step_r <= lim_r;
    if (cmd_i.set_nc)   vel_r  <= nc_vel;
    if (cmd_i.set_br)   br_r   <= cmd_i.br;
  end

  // Output register: hold a beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (cmd_i.push) begin
      ovld_r <= 1'b1;
    end else if (out_tready_i) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.push) begin
      ovel_r <= vel_r;
      obr_r  <= br_r;
    end
  end

  // Status to the controller
  assign stat_o.mul_done   = mul_done;
  assign stat_o.div_done   = div_done;
  assign stat_o.no_contact = (force_r == '0);
  assign stat_o.use_secant = (err_r != perr_r) && (perr_r != '0);
  assign stat_o.use_boost  = (err_mag > mag_of(thr_r))
                          && ((err_pos && perr_pos) || (err_neg && perr_neg))
                          && (err_mag > mag_of(perr_r));
  assign stat_o.stiff_nz   = (stiff_r != '0);
  assign stat_o.out_free   = !ovld_r || out_tready_i;

  assign out_tvalid_o = ovld_r;
  assign out_vel_o    = ovel_r;
  assign out_br_o     = obr_r;

endmodule

/* rtl/core/wfs_ctrl.sv */
// Controller of the wall force servo: sequences target force, threshold,
// limit, branch step and velocity through the datapath. Depends on wfs_pkg.
module wfs_ctrl import wfs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid_i,
  output logic  in_tready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_TF_GO  = 5'd1;
  localparam logic [4:0] S_TF_WT  = 5'd2;
  localparam logic [4:0] S_THR_GO = 5'd3;
  localparam logic [4:0] S_THR_WT = 5'd4;
  localparam logic [4:0] S_LIM_GO = 5'd5;
  localparam logic [4:0] S_LIM_WT = 5'd6;
  localparam logic [4:0] S_DECIDE = 5'd7;
  localparam logic [4:0] S_BST_GO = 5'd8;
  localparam logic [4:0] S_BST_WT = 5'd9;
  localparam logic [4:0] S_NUM_GO = 5'd10;
  localparam logic [4:0] S_NUM_WT = 5'd11;
  localparam logic [4:0] S_SEC_GO = 5'd12;
  localparam logic [4:0] S_SEC_WT = 5'd13;
  localparam logic [4:0] S_STF_GO = 5'd14;
  localparam logic [4:0] S_STF_WT = 5'd15;
  localparam logic [4:0] S_VEL_GO = 5'd16;
  localparam logic [4:0] S_VEL_WT = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  cmd_t       cmd;

  assign in_tready_o = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_TF;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid_i) begin
          cmd.load  = 1'b1;
          state_nxt = S_TF_GO;
        end
      end
      S_TF_GO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_TF_WT;
      end
      S_TF_WT: begin
        if (stat_i.mul_done) begin
          cmd.cap   = 1'b1;
          state_nxt = S_THR_GO;
        end
      end
      S_THR_GO: begin
        cmd.op     = OP_THR;
        cmd.mul_go = 1'b1;
        state_nxt  = S_THR_WT;
      end
      S_THR_WT: begin
        cmd.op = OP_THR;
        if (stat_i.mul_done) begin
          cmd.cap   = 1'b1;
          state_nxt = S_LIM_GO;
        end
      end
      S_LIM_GO: begin
        cmd.op     = OP_LIM;
        cmd.mul_go = 1'b1;
        state_nxt  = S_LIM_WT;
      end
      S_LIM_WT: begin
        cmd.op = OP_LIM;
        if (stat_i.mul_done) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_br = 1'b1;
        if (stat_i.no_contact) begin
          cmd.br     = BR_NONE;
          cmd.set_nc = 1'b1;
          state_nxt  = S_FIN;
        end else if (stat_i.use_secant && stat_i.use_boost) begin
          cmd.br    = BR_BOOST;
          state_nxt = S_BST_GO;
        end else if (stat_i.use_secant) begin
          cmd.br    = BR_SECANT;
          state_nxt = S_NUM_GO;
        end else if (stat_i.stiff_nz) begin
          cmd.br    = BR_STIFF;
          state_nxt = S_STF_GO;
        end else begin
          cmd.br       = BR_FULL;
          cmd.take_lim = 1'b1;
          state_nxt    = S_VEL_GO;
        end
      end
      S_BST_GO: begin
        cmd.op     = OP_BST;
        cmd.mul_go = 1'b1;
        state_nxt  = S_BST_WT;
      end
      S_BST_WT: begin
        cmd.op = OP_BST;
        if (stat_i.mul_done) begin
          cmd.cap   = 1'b1;
          state_nxt = S_VEL_GO;
        end
      end
      S_NUM_GO: begin
        cmd.op     = OP_NUM;
        cmd.mul_go = 1'b1;
        state_nxt  = S_NUM_WT;
      end
      S_NUM_WT: begin
        cmd.op = OP_NUM;
        if (stat_i.mul_done) begin
          cmd.cap   = 1'b1;
          state_nxt = S_SEC_GO;
        end
      end
      S_SEC_GO: begin
        cmd.op     = OP_SEC;
        cmd.div_go = 1'b1;
        state_nxt  = S_SEC_WT;
      end
      S_SEC_WT: begin
        cmd.op = OP_SEC;
        if (stat_i.div_done) begin
          cmd.cap   = 1'b1;
          state_nxt = S_VEL_GO;
        end
      end
      S_STF_GO: begin
        cmd.op     = OP_STF;
        cmd.div_go = 1'b1;
        state_nxt  = S_STF_WT;
      end
      S_STF_WT: begin
        cmd.op = OP_STF;
        if (stat_i.div_done) begin
          cmd.cap   = 1'b1;
          state_nxt = S_VEL_GO;
        end
      end
      S_VEL_GO: begin
        cmd.op     = OP_VEL;
        cmd.div_go = 1'b1;
        state_nxt  = S_VEL_WT;
      end
      S_VEL_WT: begin
        cmd.op = OP_VEL;
        if (stat_i.div_done) begin
          cmd.cap   = 1'b1;
          cmd.upd   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd_o = cmd;

endmodule

/* rtl/core/wfs_checker.sv */
// Port-level checks for the wall force servo, bound to the top level.
// Depends on wfs_pkg and wall_force_secant_servo_defines.svh.
`include "wall_force_secant_servo_defines.svh"

module wfs_checker import wfs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [BRW-1:0]         out_tuser
);

  // Stalled result beats hold
  `WFS_CHECK_HOLD(a_out_data_hold, out_tvalid, out_tready, out_tdata)
  `WFS_CHECK_HOLD(a_out_user_hold, out_tvalid, out_tready, out_tuser)

  // Branch codes stay within the defined set
  `WFS_CHECK(a_branch_range, out_tvalid |-> (out_tuser <= BR_FULL))

  // An accepted item keeps the block busy on the next cycle
  `WFS_CHECK(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready)

endmodule

bind wall_force_secant_servo wfs_checker u_wfs_checker (.*);
